// ----- hw/rtl/ppac_pkg.sv -----
`default_nettype none

package ppac_pkg;

  localparam int unsigned KeyW = 22;
  localparam int unsigned CntW = 32;

  localparam logic [CntW-1:0] ThreshReset = 32'd20000;
  localparam logic [CntW-1:0] CntMax      = {CntW{1'b1}};

  // One access word as it moves down the row of cells
  typedef struct packed {
    logic            vld;      // slot holds an access
    logic            done;     // a cell has already taken it
    logic            created;  // that cell was claimed by it
    logic            wr;       // write access
    logic [KeyW-1:0] key;      // process identifier
    logic [CntW-1:0] count;    // updated counter once done
  } item_t;

  // Saturating increment
  function automatic logic [CntW-1:0] cnt_bump(input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = (c == CntMax) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ppac_acc_if.sv -----
`default_nettype none

interface ppac_acc_if;
  logic                        valid;
  logic                        ready;
  logic [ppac_pkg::KeyW-1:0]   process_id;
  logic                        is_write;

  modport source (output valid, output process_id, output is_write, input ready);
  modport sink   (input valid, input process_id, input is_write, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppac_res_if.sv -----
`default_nettype none

interface ppac_res_if;
  logic                        valid;
  logic                        ready;
  logic [ppac_pkg::CntW-1:0]   access_count;
  logic                        over_threshold;
  logic                        table_full;
  logic                        new_entry;

  modport source (output valid, output access_count, output over_threshold,
                  output table_full, output new_entry, input ready);
  modport sink   (input valid, input access_count, input over_threshold,
                  input table_full, input new_entry, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppac_cell.sv -----
`default_nettype none

// One table entry: key, read and write counters, and one stage of the row.
module ppac_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire ppac_pkg::item_t item_i,
  output ppac_pkg::item_t      item_o
);

  logic                        used_q, used_d;
  logic [ppac_pkg::KeyW-1:0]   key_q, key_d;
  logic [ppac_pkg::CntW-1:0]   rcnt_q, rcnt_d;
  logic [ppac_pkg::CntW-1:0]   wcnt_q, wcnt_d;
  ppac_pkg::item_t             item_q, item_d;
  logic                        hit;
  logic                        claim;

  // Match or claim the entry, bump the chosen counter
  always_comb begin
    used_d = used_q;
    key_d  = key_q;
    rcnt_d = rcnt_q;
    wcnt_d = wcnt_q;
    item_d = item_i;
    hit    = item_i.vld && !item_i.done && used_q && (key_q == item_i.key);
    claim  = item_i.vld && !item_i.done && !used_q;
    if (claim) begin
      used_d         = 1'b1;
      key_d          = item_i.key;
      item_d.created = 1'b1;
    end
    if (hit || claim) begin
      item_d.done = 1'b1;
      if (item_i.wr) begin
        wcnt_d       = ppac_pkg::cnt_bump(wcnt_q);
        item_d.count = wcnt_d;
      end else begin
        rcnt_d       = ppac_pkg::cnt_bump(rcnt_q);
        item_d.count = rcnt_d;
      end
    end
  end

  // Entry state and stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      rcnt_q <= '0;
      wcnt_q <= '0;
      item_q <= '0;
    end else if (adv_i) begin
      used_q <= used_d;
      rcnt_q <= rcnt_d;
      wcnt_q <= wcnt_d;
      item_q <= item_d;
    end
  end

  // Keys stay undefined until claimed
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q <= key_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ppac_out_stage.sv -----
`default_nettype none

// Result register: form the result word, compare against the threshold,
// and stall the row while a word waits.
module ppac_out_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ppac_pkg::item_t           item_i,
  input  wire logic [ppac_pkg::CntW-1:0] thresh_i,
  output logic                           adv_o,
  ppac_res_if.source                     res_o
);

  logic                        valid_q;
  logic [ppac_pkg::CntW-1:0]   count_q, count_d;
  logic                        over_q, over_d;
  logic                        full_q, full_d;
  logic                        new_q, new_d;

  assign adv_o = !valid_q || res_o.ready;

  // An access that reached the end untaken found no room
  always_comb begin
    count_d = item_i.done ? item_i.count : '0;
    full_d  = !item_i.done;
    new_d   = item_i.done && item_i.created;
    over_d  = item_i.done && (item_i.count > thresh_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= item_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      count_q <= count_d;
      over_q  <= over_d;
      full_q  <= full_d;
      new_q   <= new_d;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.access_count   = count_q;
  assign res_o.over_threshold = over_q;
  assign res_o.table_full     = full_q;
  assign res_o.new_entry      = new_q;

endmodule

`default_nettype wire

// ----- hw/rtl/per_process_access_counter.sv -----
// Channel   Dir  Handshake     Word
// acc_i     in   valid/ready   process_id[21:0], is_write
// res_o     out  valid/ready   access_count[31:0], over_threshold, table_full, new_entry
// cfg       in   cfg_we_i      cfg_wdata_i[31:0] -> alert threshold
//
// Each access walks the row of ENTRIES cells, one cell per cycle, and is
// taken by the cell that holds its key or by the first free one; the result
// register follows the last cell. One access enters per cycle; both rates
// hold only while no result is held at res_o, which stalls the whole row and
// drops acc_i.ready. Reset clears all entries at once, the threshold to 20000.
`default_nettype none

module per_process_access_counter #(
  parameter int unsigned ENTRIES = 256
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  ppac_acc_if.sink                       acc_i,
  ppac_res_if.source                     res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [ppac_pkg::CntW-1:0] cfg_wdata_i
);

  logic [ppac_pkg::CntW-1:0] thresh_q;
  logic                      adv;
  ppac_pkg::item_t           row [ENTRIES+1];

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ppac_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign acc_i.ready = adv;

  // Feed the head of the row
  always_comb begin
    row[0]         = '0;
    row[0].vld     = acc_i.valid;
    row[0].wr      = acc_i.is_write;
    row[0].key     = acc_i.process_id;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ppac_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .item_i (row[g]),
      .item_o (row[g+1])
    );
  end

  ppac_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (row[ENTRIES]),
    .thresh_i (thresh_q),
    .adv_o    (adv),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ppac_checker.sv -----
`default_nettype none

module ppac_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [ppac_pkg::CntW-1:0] out_count_i,
  input wire logic                      out_over_i,
  input wire logic                      out_full_i,
  input wire logic                      out_new_i
);

  // A full table reports nothing else
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_full_i |-> out_count_i == '0 && !out_over_i && !out_new_i)
    else $error("table_full result carries count or flags");

  // A fresh entry starts at one
  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_new_i |-> out_count_i == 32'd1 && !out_full_i)
    else $error("new entry result not at count one");

  // A waiting result blocks new accesses
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("access accepted while result stalled");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i))
    else $error("stalled result changed");

endmodule

bind per_process_access_counter ppac_checker u_ppac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (acc_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_count_i (res_o.access_count),
  .out_over_i  (res_o.over_threshold),
  .out_full_i  (res_o.table_full),
  .out_new_i   (res_o.new_entry)
);

`default_nettype wire
